[hw/rtl/lre_pkg.sv]
`default_nettype none

package lre_pkg;

    localparam int MAX_DEGREE = 63;
    localparam int FRAC_BITS  = 30;     // coefficient fraction bits
    localparam int DATA_FRAC  = 30;     // data is Q2.30
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 6;
    localparam int TABLE_LEN  = 64;

    localparam int COEF_W = FRAC_BITS + 1;      // a_j < 2.0
    localparam int PB_W   = DATA_W + FRAC_BITS; // |P_{j-1}| * b_j
    localparam int PA_W   = DATA_W + COEF_W;    // |xp| * a_j
    localparam int SUM_W  = DATA_W + 3;

    localparam logic [IDX_W-1:0] DEGREE_RESET = IDX_W'(31);

    localparam longint unsigned COEF_ONE = 64'd1 << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] DATA_ONE = DATA_W'(64'd1 << DATA_FRAC);

    // r_j = round(1/(j+1)) with FRAC_BITS fraction bits, entry j
    localparam longint unsigned RECIP_TABLE [0:TABLE_LEN-1] = '{
        (COEF_ONE + 1/2) / 1,   (COEF_ONE + 2/2) / 2,   (COEF_ONE + 3/2) / 3,
        (COEF_ONE + 4/2) / 4,   (COEF_ONE + 5/2) / 5,   (COEF_ONE + 6/2) / 6,
        (COEF_ONE + 7/2) / 7,   (COEF_ONE + 8/2) / 8,   (COEF_ONE + 9/2) / 9,
        (COEF_ONE + 10/2) / 10, (COEF_ONE + 11/2) / 11, (COEF_ONE + 12/2) / 12,
        (COEF_ONE + 13/2) / 13, (COEF_ONE + 14/2) / 14, (COEF_ONE + 15/2) / 15,
        (COEF_ONE + 16/2) / 16, (COEF_ONE + 17/2) / 17, (COEF_ONE + 18/2) / 18,
        (COEF_ONE + 19/2) / 19, (COEF_ONE + 20/2) / 20, (COEF_ONE + 21/2) / 21,
        (COEF_ONE + 22/2) / 22, (COEF_ONE + 23/2) / 23, (COEF_ONE + 24/2) / 24,
        (COEF_ONE + 25/2) / 25, (COEF_ONE + 26/2) / 26, (COEF_ONE + 27/2) / 27,
        (COEF_ONE + 28/2) / 28, (COEF_ONE + 29/2) / 29, (COEF_ONE + 30/2) / 30,
        (COEF_ONE + 31/2) / 31, (COEF_ONE + 32/2) / 32, (COEF_ONE + 33/2) / 33,
        (COEF_ONE + 34/2) / 34, (COEF_ONE + 35/2) / 35, (COEF_ONE + 36/2) / 36,
        (COEF_ONE + 37/2) / 37, (COEF_ONE + 38/2) / 38, (COEF_ONE + 39/2) / 39,
        (COEF_ONE + 40/2) / 40, (COEF_ONE + 41/2) / 41, (COEF_ONE + 42/2) / 42,
        (COEF_ONE + 43/2) / 43, (COEF_ONE + 44/2) / 44, (COEF_ONE + 45/2) / 45,
        (COEF_ONE + 46/2) / 46, (COEF_ONE + 47/2) / 47, (COEF_ONE + 48/2) / 48,
        (COEF_ONE + 49/2) / 49, (COEF_ONE + 50/2) / 50, (COEF_ONE + 51/2) / 51,
        (COEF_ONE + 52/2) / 52, (COEF_ONE + 53/2) / 53, (COEF_ONE + 54/2) / 54,
        (COEF_ONE + 55/2) / 55, (COEF_ONE + 56/2) / 56, (COEF_ONE + 57/2) / 57,
        (COEF_ONE + 58/2) / 58, (COEF_ONE + 59/2) / 59, (COEF_ONE + 60/2) / 60,
        (COEF_ONE + 61/2) / 61, (COEF_ONE + 62/2) / 62, (COEF_ONE + 63/2) / 63,
        (COEF_ONE + 64/2) / 64
    };

    // controller -> datapath
    typedef struct packed {
        logic             load;     // latch clamped x, value = 1.0
        logic             emit_x;   // value = x, start recurrence
        logic             mul1;     // x*P_j and |P_{j-1}|*b_j
        logic             rnd;      // round both products
        logic             mul2;     // |xp|*a_j
        logic             sum;      // subtract, saturate, advance
        logic [IDX_W-1:0] j;
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/lre_dpath.sv]
`default_nettype none

module lre_dpath (
    input  wire logic                                 clk,
    input  wire logic signed [lre_pkg::DATA_W-1:0]    x_value,
    input  wire lre_pkg::cmd_t                        cmd,
    output logic signed [lre_pkg::DATA_W-1:0]         poly_value
);

    localparam int DW = lre_pkg::DATA_W;

    logic signed [DW-1:0]                x_reg, cur_reg, prev_reg, value_reg;
    logic signed [2*DW-1:0]              prod_reg;
    logic [lre_pkg::PB_W-1:0]            pb_reg;
    logic                                prev_neg_reg;
    logic [DW-1:0]                       xp_mag_reg, tb_mag_reg;
    logic                                xp_neg_reg;
    logic [lre_pkg::PA_W-1:0]            pa_reg;

    logic signed [DW-1:0]                x_clamp;
    logic [DW-1:0]                       prev_mag;
    longint unsigned                     recip;
    logic [lre_pkg::COEF_W-1:0]          coef_a;
    logic [lre_pkg::FRAC_BITS-1:0]       coef_b;
    logic [2*DW-1:0]                     prod_mag;
    logic [2*DW-1:0]                     xp_sum;
    logic [lre_pkg::PB_W:0]              tb_sum;
    logic [lre_pkg::PA_W:0]              ta_sum;
    logic [DW:0]                         ta_mag;
    logic signed [lre_pkg::SUM_W-1:0]    ta_s, tb_s, diff;
    logic signed [DW-1:0]                next_val;

    assign poly_value = value_reg;

    always_comb
    begin
        if (x_value > lre_pkg::DATA_ONE)
            x_clamp = lre_pkg::DATA_ONE;
        else if (x_value < -lre_pkg::DATA_ONE)
            x_clamp = -lre_pkg::DATA_ONE;
        else
            x_clamp = x_value;
    end

    always_comb
    begin
        recip  = lre_pkg::RECIP_TABLE[cmd.j];
        coef_a = lre_pkg::COEF_W'((lre_pkg::COEF_ONE << 1) - recip);
        coef_b = lre_pkg::FRAC_BITS'(lre_pkg::COEF_ONE - recip);
    end

    assign prev_mag = prev_reg[DW-1] ? (~prev_reg + 1'b1) : prev_reg;
    assign prod_mag = prod_reg[2*DW-1] ? (~prod_reg + 1'b1) : prod_reg;

    // round to nearest, ties away from zero, on magnitudes
    assign xp_sum = prod_mag + ((2*DW)'(1) << (lre_pkg::DATA_FRAC - 1));
    assign tb_sum = {1'b0, pb_reg} + ((lre_pkg::PB_W+1)'(1) << (lre_pkg::FRAC_BITS - 1));
    assign ta_sum = {1'b0, pa_reg} + ((lre_pkg::PA_W+1)'(1) << (lre_pkg::FRAC_BITS - 1));
    assign ta_mag = (DW+1)'(ta_sum >> lre_pkg::FRAC_BITS);

    always_comb
    begin
        ta_s = xp_neg_reg ? -lre_pkg::SUM_W'(ta_mag) : lre_pkg::SUM_W'(ta_mag);
        tb_s = prev_neg_reg ? -lre_pkg::SUM_W'(tb_mag_reg) : lre_pkg::SUM_W'(tb_mag_reg);
        diff = ta_s - tb_s;
        if (diff > $signed(lre_pkg::SUM_W'({1'b0, {(DW-1){1'b1}}})))
            next_val = {1'b0, {(DW-1){1'b1}}};
        else if (diff < $signed(lre_pkg::SUM_W'({{(lre_pkg::SUM_W-DW+1){1'b1}},
                                                  {(DW-1){1'b0}}})))
            next_val = {1'b1, {(DW-1){1'b0}}};
        else
            next_val = DW'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= x_clamp;
            prev_reg  <= lre_pkg::DATA_ONE;
            value_reg <= lre_pkg::DATA_ONE;
        end
        if (cmd.emit_x)
        begin
            cur_reg   <= x_reg;
            value_reg <= x_reg;
        end
        if (cmd.mul1)
        begin
            prod_reg     <= x_reg * cur_reg;
            pb_reg       <= lre_pkg::PB_W'(prev_mag) * lre_pkg::PB_W'(coef_b);
            prev_neg_reg <= prev_reg[DW-1];
        end
        if (cmd.rnd)
        begin
            xp_mag_reg <= DW'(xp_sum >> lre_pkg::DATA_FRAC);
            xp_neg_reg <= prod_reg[2*DW-1];
            tb_mag_reg <= DW'(tb_sum >> lre_pkg::FRAC_BITS);
        end
        if (cmd.mul2)
            pa_reg <= lre_pkg::PA_W'(xp_mag_reg) * lre_pkg::PA_W'(coef_a);
        if (cmd.sum)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= next_val;
            value_reg <= next_val;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lre_ctrl.sv]
`default_nettype none

module lre_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lre_pkg::IDX_W-1:0]     cfg_data,
    output logic                               result_valid,
    output logic [lre_pkg::IDX_W-1:0]          poly_index,
    output logic                               last,
    output lre_pkg::cmd_t                      cmd
);

    localparam int IW = lre_pkg::IDX_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_P1   = 6'b000010,
        ST_MUL1 = 6'b000100,
        ST_RND  = 6'b001000,
        ST_MUL2 = 6'b010000,
        ST_SUM  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   degree_reg, degree_next;
    logic [IW-1:0]   n_reg, n_next;
    logic [IW-1:0]   j_reg, j_next;
    logic            valid_reg, valid_next;
    logic [IW-1:0]   index_reg, index_next;
    logic            last_reg, last_next;
    logic [IW-1:0]   n_eff;
    logic [IW-1:0]   j_inc;

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = ~busy;
    assign result_valid = valid_reg;
    assign poly_index   = index_reg;
    assign last         = last_reg;

    assign n_eff = (degree_reg > IW'(lre_pkg::MAX_DEGREE)) ? IW'(lre_pkg::MAX_DEGREE)
                                                           : degree_reg;
    assign j_inc = j_reg + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        degree_next = degree_reg;
        n_next      = n_reg;
        j_next      = j_reg;
        valid_next  = 1'b0;
        index_next  = index_reg;
        last_next   = last_reg;
        cmd         = '0;
        cmd.j       = j_reg;

        if (cfg_valid && cfg_ready)
            degree_next = cfg_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    valid_next = 1'b1;
                    index_next = '0;
                    last_next  = (n_eff == '0);
                    n_next     = n_eff;
                    state_next = (n_eff == '0) ? ST_IDLE : ST_P1;
                end
            end
            ST_P1:
            begin
                cmd.emit_x = 1'b1;
                valid_next = 1'b1;
                index_next = IW'(1);
                last_next  = (n_reg == IW'(1));
                j_next     = IW'(1);
                state_next = (n_reg == IW'(1)) ? ST_IDLE : ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                valid_next = 1'b1;
                index_next = j_inc;
                last_next  = (j_inc == n_reg);
                j_next     = j_inc;
                state_next = (j_inc == n_reg) ? ST_IDLE : ST_MUL1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            degree_reg <= lre_pkg::DEGREE_RESET;
            n_reg      <= '0;
            j_reg      <= '0;
            valid_reg  <= 1'b0;
            index_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            degree_reg <= degree_next;
            n_reg      <= n_next;
            j_reg      <= j_next;
            valid_reg  <= valid_next;
            index_reg  <= index_next;
            last_reg   <= last_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/legendre_row_eval.sv]
`default_nettype none

// Legendre row evaluator: pulse start with x_value (Q2.30, clamped to [-1,1]) while
// busy is low, and P_0(x)..P_n(x) come out in rising degree on result_valid
// strobes, one cycle each, with last on degree n (n = degree register, 0..63).
// The receiver cannot stall, so every strobe must be taken. P_0 appears the
// cycle after start, P_1 the cycle after that, and each further value goes
// through the product, round, coefficient product and subtract/saturate steps of
// the three-multiplier datapath; busy falls as the last value comes out (it is
// not raised at all for n = 0), and a new start is taken only while busy is low.
// The degree register is written over the cfg channel only while busy is low.
module legendre_row_eval (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [lre_pkg::DATA_W-1:0]    x_value,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lre_pkg::IDX_W-1:0]            cfg_data,
    output logic                                      result_valid,
    output logic [lre_pkg::IDX_W-1:0]                 poly_index,
    output logic signed [lre_pkg::DATA_W-1:0]         poly_value,
    output logic                                      last
);

    lre_pkg::cmd_t cmd;

    lre_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .poly_index   (poly_index),
        .last         (last),
        .cmd          (cmd)
    );

    lre_dpath u_dpath (
        .clk        (clk),
        .x_value    (x_value),
        .cmd        (cmd),
        .poly_value (poly_value)
    );

endmodule

`default_nettype wire

[hw/rtl/lre_checker.sv]
`default_nettype none

module lre_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic                                 busy,
    input  wire logic                                 result_valid,
    input  wire logic [lre_pkg::IDX_W-1:0]            poly_index,
    input  wire logic signed [lre_pkg::DATA_W-1:0]    poly_value,
    input  wire logic                                 last
);

    // an accepted start gives P_0 on the next beat
    a_first_beat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> result_valid && (poly_index == '0))
        else $error("start not followed by P_0 beat");

    a_p0_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (poly_index == '0) |-> (poly_value == lre_pkg::DATA_ONE))
        else $error("P_0 is not 1.0");

    a_p1_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (poly_index == lre_pkg::IDX_W'(1)) |->
            (poly_value <= lre_pkg::DATA_ONE) && (poly_value >= -lre_pkg::DATA_ONE))
        else $error("P_1 outside [-1,1]");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-last beat while idle");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("still busy on last beat");

endmodule

bind legendre_row_eval lre_checker u_lre_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .poly_index   (poly_index),
    .poly_value   (poly_value),
    .last         (last)
);

`default_nettype wire
